FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/tmsw_pkg.sv
// ----------------------------------------------------------------------------
// tmsw_pkg
// Types and constants of the text-mode screen writer.
// ----------------------------------------------------------------------------
package tmsw_pkg;

	localparam int POS_W  = 11;
	localparam int CODE_W = 9;
	localparam int WORD_W = 16;
	localparam int ATTR_W = 8;
	localparam int CHAR_W = 8;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic REG_ATTR = 1'b0;

	localparam logic [CODE_W-1:0] CODE_NEWLINE   = 9'd10;
	localparam logic [CODE_W-1:0] CODE_BACKSPACE = 9'h100;
	localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
	localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h07;

	typedef struct packed {
		logic              operation;
		logic [CODE_W-1:0] char_code;
		logic [POS_W-1:0]  cell_address;
	} cmd_t;

	typedef struct packed {
		logic [POS_W-1:0]  cursor_position;
		logic [WORD_W-1:0] cell_word;
	} rsp_t;

	typedef struct packed {
		logic advance;
		logic newline;
		logic backspace;
	} cur_op_t;

endpackage

FILE: src/tmsw_ram.sv
// ----------------------------------------------------------------------------
// tmsw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmsw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/tmsw_regs.sv
// ----------------------------------------------------------------------------
// tmsw_regs
// APB register file: holds the text attribute byte.
// ----------------------------------------------------------------------------
module tmsw_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         reg_idx,
	input  logic [tmsw_pkg::APB_DW-1:0]  pwdata,
	output logic [tmsw_pkg::APB_DW-1:0]  prdata,
	output logic [tmsw_pkg::ATTR_W-1:0]  attr
);
	import tmsw_pkg::*;

	logic [ATTR_W-1:0] attr_q;
	logic              wr;

	assign wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (wr && reg_idx == REG_ATTR) begin
			attr_q <= pwdata[ATTR_W-1:0];
		end
	end

	assign prdata = (reg_idx == REG_ATTR) ? {{(APB_DW-ATTR_W){1'b0}}, attr_q} : '0;
	assign attr   = attr_q;

endmodule

FILE: src/tmsw_cursor.sv
// ----------------------------------------------------------------------------
// tmsw_cursor
// Cursor tracker: linear index plus row and column, with scroll detect.
// ----------------------------------------------------------------------------
module tmsw_cursor #(
	parameter int COLUMNS    = 80,
	parameter int SCROLL_ROW = 24,
	parameter int ADDR_W     = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tmsw_pkg::cur_op_t   op,
	output logic [ADDR_W-1:0]   cur,
	output logic                scroll
);
	import tmsw_pkg::*;

	localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int ROW_W = $clog2(SCROLL_ROW + 1);
	localparam logic [COL_W-1:0]  COL_LAST = COL_W'(COLUMNS - 1);
	localparam logic [ADDR_W-1:0] COL_ADDR = ADDR_W'(COLUMNS);
	localparam logic [ROW_W-1:0]  ROW_WRAP = ROW_W'(SCROLL_ROW);

	logic [ADDR_W-1:0] cur_q, cur_n, cur_f;
	logic [ROW_W-1:0]  row_q, row_n, row_f;
	logic [COL_W-1:0]  col_q, col_n;

	always_comb begin
		cur_n = cur_q;
		row_n = row_q;
		col_n = col_q;
		if (op.newline) begin
			cur_n = cur_q + COL_ADDR - ADDR_W'(col_q);
			row_n = row_q + ROW_W'(1);
			col_n = '0;
		end else if (op.backspace) begin
			if (cur_q != '0) begin
				cur_n = cur_q - ADDR_W'(1);
				if (col_q == '0) begin
					col_n = COL_LAST;
					row_n = row_q - ROW_W'(1);
				end else begin
					col_n = col_q - COL_W'(1);
				end
			end
		end else if (op.advance) begin
			cur_n = cur_q + ADDR_W'(1);
			if (col_q == COL_LAST) begin
				col_n = '0;
				row_n = row_q + ROW_W'(1);
			end else begin
				col_n = col_q + COL_W'(1);
			end
		end
		scroll = (row_n == ROW_WRAP);
		cur_f  = scroll ? cur_n - COL_ADDR : cur_n;
		row_f  = scroll ? row_n - ROW_W'(1) : row_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			row_q <= '0;
			col_q <= '0;
		end else if (op.advance | op.newline | op.backspace) begin
			cur_q <= cur_f;
			row_q <= row_f;
			col_q <= col_n;
		end
	end

	assign cur = cur_q;

endmodule

FILE: src/text_mode_screen_writer_unit.sv
// ----------------------------------------------------------------------------
// text_mode_screen_writer_unit
// Text-mode screen writer with cell memory, cursor and APB attribute register.
//
// After reset the cell memory is cleared one cell per cycle, with busy high. An
// item is taken when start is high and busy low; result_valid is registered from
// the READ or BLANK state, high for exactly one cycle, and the receiver cannot
// stall it. A read goes through the READ state and an ordinary put through the
// BLANK state; the cell RAM has a synchronous write and registered read data. A
// put that reaches row SCROLL_ROW scrolls through the same RAM port pair one cell
// per cycle, in the states COPY, DRAIN, ZERO and then BLANK.
// ----------------------------------------------------------------------------
module text_mode_screen_writer_unit #(
	parameter int COLUMNS    = 80,
	parameter int SCROLL_ROW = 24,
	parameter int TOTAL_ROWS = 25
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tmsw_pkg::APB_AW-1:0]  paddr,
	input  logic [tmsw_pkg::APB_DW-1:0]  pwdata,
	output logic [tmsw_pkg::APB_DW-1:0]  prdata,
	output logic                         pready,
	input  logic                         start,
	output logic                         busy,
	input  tmsw_pkg::cmd_t               item,
	output logic                         result_valid,
	output tmsw_pkg::rsp_t               result
);
	import tmsw_pkg::*;

	localparam int CELL_COUNT = TOTAL_ROWS * COLUMNS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(SCROLL_ROW * COLUMNS - 1);
	localparam logic [ADDR_W-1:0] COL_ADDR  = ADDR_W'(COLUMNS);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_COPY  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_ZERO  = 3'd5;
	localparam logic [2:0] ST_BLANK = 3'd6;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] ptr_q;
	logic              cpy_v_s1;
	logic [ADDR_W-1:0] cpy_dst_s1;
	logic              done_q;
	logic              rd_ok_q;
	rsp_t              res_q;

	logic              accept, is_put, rd_in_range, scroll;
	cur_op_t           cur_op;
	logic [ADDR_W-1:0] cur;
	logic [ATTR_W-1:0] attr;

	logic              we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [WORD_W-1:0] wdata, rdata;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start & ~busy;
	assign is_put = accept & (item.operation == OP_PUT);

	assign cur_op.newline   = is_put & (item.char_code == CODE_NEWLINE);
	assign cur_op.backspace = is_put & (item.char_code == CODE_BACKSPACE);
	assign cur_op.advance   = is_put & (item.char_code != CODE_NEWLINE)
		& (item.char_code != CODE_BACKSPACE);

	assign rd_in_range = 32'(item.cell_address) < 32'(CELL_COUNT);

	tmsw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.reg_idx (paddr[APB_AW-1]),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.attr    (attr)
	);
	assign pready = 1'b1;

	tmsw_cursor #(
		.COLUMNS    (COLUMNS),
		.SCROLL_ROW (SCROLL_ROW),
		.ADDR_W     (ADDR_W)
	) u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (cur_op),
		.cur    (cur),
		.scroll (scroll)
	);

	tmsw_ram #(
		.WIDTH (WORD_W),
		.DEPTH (CELL_COUNT)
	) u_cells (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// copy write-back has priority; only COPY and DRAIN see it
	always_comb begin
		we    = 1'b0;
		waddr = cur;
		wdata = '0;
		if (cpy_v_s1) begin
			we    = 1'b1;
			waddr = cpy_dst_s1;
			wdata = rdata;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					we    = 1'b1;
					waddr = ptr_q;
				end
				ST_IDLE: begin
					if (cur_op.advance) begin
						we    = 1'b1;
						wdata = {attr, item.char_code[CHAR_W-1:0]};
					end
				end
				ST_ZERO: begin
					we    = 1'b1;
					waddr = ptr_q;
				end
				ST_BLANK: begin
					we    = 1'b1;
					wdata = {attr, BLANK_CHAR};
				end
				default: ;
			endcase
		end
	end

	assign raddr = (state_q == ST_COPY) ? ptr_q : ADDR_W'(item.cell_address);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			ptr_q    <= '0;
			cpy_v_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			cpy_v_s1 <= (state_q == ST_COPY);
			case (state_q)
				ST_CLEAR: begin
					if (ptr_q == LAST_CELL) begin
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + ADDR_W'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (item.operation == OP_READ) begin
							state_q <= ST_READ;
						end else if (scroll) begin
							state_q <= ST_COPY;
							ptr_q   <= COL_ADDR;
						end else begin
							state_q <= ST_BLANK;
						end
					end
				end
				ST_READ: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_COPY: begin
					if (ptr_q == COPY_LAST) begin
						state_q <= ST_DRAIN;
					end else begin
						ptr_q <= ptr_q + ADDR_W'(1);
					end
				end
				ST_DRAIN: begin
					ptr_q   <= cur;
					state_q <= ST_ZERO;
				end
				ST_ZERO: begin
					if (ptr_q == COPY_LAST) begin
						state_q <= ST_BLANK;
					end else begin
						ptr_q <= ptr_q + ADDR_W'(1);
					end
				end
				ST_BLANK: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cpy_dst_s1 <= ptr_q - COL_ADDR;
		if (accept) begin
			rd_ok_q <= rd_in_range;
		end
		if (state_q == ST_READ) begin
			res_q.cursor_position <= POS_W'(cur);
			res_q.cell_word       <= rd_ok_q ? rdata : '0;
		end else if (state_q == ST_BLANK) begin
			res_q.cursor_position <= POS_W'(cur);
			res_q.cell_word       <= '0;
		end
	end

	assign result_valid = done_q;
	assign result       = res_q;

endmodule

FILE: src/tmsw_checker.sv
// ----------------------------------------------------------------------------
// tmsw_checker
// Port-level checks of the screen writer's command and result timing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tmsw_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input tmsw_pkg::cmd_t item,
	input logic           result_valid,
	input tmsw_pkg::rsp_t result
);
	import tmsw_pkg::*;

	logic take;
	assign take = start & ~busy;

	`ASSERT_NXT(a_busy_after_take, clk, arst_n, take, busy, "busy not raised after transfer")
	`ASSERT_NXT(a_idle_holds, clk, arst_n, !busy && !start, !busy, "busy rose with no transfer")
	`ASSERT_NXT(a_single_result, clk, arst_n, result_valid, !result_valid, "back-to-back results")
	`ASSERT_IMP(a_read_latency, clk, arst_n, take && item.operation == OP_READ,
		##2 result_valid, "read result not two cycles after transfer")
	`ASSERT_IMP(a_no_orphan_result, clk, arst_n, result_valid && result.cell_word != '0,
		$past(busy), "read data shown without a transfer in progress")

endmodule

bind text_mode_screen_writer_unit tmsw_checker u_tmsw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.item         (item),
	.result_valid (result_valid),
	.result       (result)
);

FILE: tb/tb_text_mode_screen_writer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_mode_screen_writer_unit
// Sends put and read commands to the screen writer and keeps its own copy of
// the cell memory, cursor and attribute. Every result transfer is checked
// against that copy. The attribute register is rewritten over APB between
// traffic phases, and the sender pace varies from phase to phase.
// ----------------------------------------------------------------------------
module tb_text_mode_screen_writer_unit;
	import tmsw_pkg::*;

	localparam int COLUMNS    = 80;
	localparam int SCROLL_ROW = 24;
	localparam int TOTAL_ROWS = 25;
	localparam int CELL_COUNT = TOTAL_ROWS * COLUMNS;
	localparam int ADDR_MAX   = (1 << POS_W) - 1;
	localparam int TAIL_CYCLES = 8;
	localparam int LIMIT_CYCLES = 10_000_000;
	localparam logic [APB_AW-1:0] ATTR_ADDR = APB_AW'(4 * int'(REG_ATTR));

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              start;
	logic              busy;
	cmd_t              item;
	logic              result_valid;
	rsp_t              result;

	logic [WORD_W-1:0] screen_model [CELL_COUNT];
	logic [POS_W-1:0]  cursor_model;
	logic [ATTR_W-1:0] attr_model;
	rsp_t              screen_rsp_q [$];
	int unsigned       mismatch_count;
	int unsigned       sender_idle_pct;
	int unsigned       cycle_count;

	text_mode_screen_writer_unit #(
		.COLUMNS   (COLUMNS),
		.SCROLL_ROW(SCROLL_ROW),
		.TOTAL_ROWS(TOTAL_ROWS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.result_valid(result_valid),
		.result      (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_text_mode_screen_writer_unit: FAIL");
		$finish;
	end

	function automatic void report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch %0d: %s expected 0x%0h actual 0x%0h", mismatch_count, what,
				want, got);
	endfunction

	function automatic void store_cell(input int unsigned idx, input logic [CHAR_W-1:0] ch);
		if (idx < CELL_COUNT)
			screen_model[idx] = {attr_model, ch};
	endfunction

	// screen and cursor update for one accepted command
	function automatic rsp_t screen_apply(input cmd_t c);
		rsp_t        r;
		int unsigned pos;
		r = '0;
		pos = cursor_model;
		if (c.operation == OP_READ) begin
			if (c.cell_address < CELL_COUNT)
				r.cell_word = screen_model[c.cell_address];
		end else begin
			if (c.char_code == CODE_NEWLINE) begin
				pos = pos + COLUMNS - pos % COLUMNS;
			end else if (c.char_code == CODE_BACKSPACE) begin
				if (pos > 0)
					pos--;
			end else begin
				store_cell(pos, c.char_code[CHAR_W-1:0]);
				pos++;
			end
			if (pos / COLUMNS >= SCROLL_ROW) begin
				for (int i = 0; i < (SCROLL_ROW - 1) * COLUMNS; i++)
					screen_model[i] = screen_model[i + COLUMNS];
				pos -= COLUMNS;
				for (int i = pos; i < SCROLL_ROW * COLUMNS; i++)
					screen_model[i] = '0;
			end
			store_cell(pos, BLANK_CHAR);
		end
		cursor_model = POS_W'(pos);
		r.cursor_position = cursor_model;
		return r;
	endfunction

	function automatic cmd_t put_cmd(input logic [CODE_W-1:0] code);
		cmd_t c;
		c.operation = OP_PUT;
		c.char_code = code;
		c.cell_address = POS_W'($urandom_range(ADDR_MAX));
		return c;
	endfunction

	function automatic cmd_t read_cmd(input int unsigned addr);
		cmd_t c;
		c.operation = OP_READ;
		c.char_code = CODE_W'($urandom_range((1 << CODE_W) - 1));
		c.cell_address = POS_W'(addr);
		return c;
	endfunction

	function automatic logic [CODE_W-1:0] rand_text_code();
		logic [CODE_W-1:0] code;
		do
			code = CODE_W'($urandom_range((1 << CODE_W) - 1));
		while (code == CODE_NEWLINE || code == CODE_BACKSPACE);
		return code;
	endfunction

	// called at a falling edge, returns at a falling edge with start still high
	task automatic send_cmd(input cmd_t c);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item <= c;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		screen_rsp_q.push_back(screen_apply(c));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		do
			@(posedge clk);
		while (screen_rsp_q.size() != 0 || busy !== 1'b0);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic apb_transfer(input logic wr, input logic [APB_DW-1:0] wdata,
			output logic [APB_DW-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ATTR_ADDR;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_attribute();
		logic [APB_DW-1:0] rd;
		apb_transfer(1'b0, '0, rd);
		if (rd[ATTR_W-1:0] !== attr_model)
			report_mismatch("text_attribute readback", attr_model, rd[ATTR_W-1:0]);
	endtask

	task automatic write_attribute(input logic [ATTR_W-1:0] value);
		logic [APB_DW-1:0] rd;
		wait_idle();
		apb_transfer(1'b1, APB_DW'(value), rd);
		attr_model = value;
		check_attribute();
	endtask

	task automatic test_reset_state();
		wait_idle();
		check_attribute();
		send_cmd(read_cmd(0));
		send_cmd(read_cmd(CELL_COUNT - 1));
		send_cmd(read_cmd(CELL_COUNT));
		send_cmd(read_cmd(ADDR_MAX));
		wait_idle();
	endtask

	task automatic test_put_special_cases();
		send_cmd(put_cmd(CODE_BACKSPACE));
		send_cmd(read_cmd(0));
		send_cmd(put_cmd(9'h000));
		send_cmd(put_cmd(9'h0FF));
		send_cmd(put_cmd(9'h101));
		send_cmd(put_cmd(9'h1FF));
		send_cmd(put_cmd(9'h10A));
		send_cmd(put_cmd(CODE_NEWLINE));
		send_cmd(put_cmd(CODE_BACKSPACE));
		send_cmd(read_cmd(COLUMNS - 1));
		for (int a = 1; a <= 5; a++)
			send_cmd(read_cmd(a));
		wait_idle();
	endtask

	task automatic test_attribute_register();
		logic [ATTR_W-1:0] values [3];
		values = '{8'hFF, 8'h00, 8'h5A};
		foreach (values[i]) begin
			write_attribute(values[i]);
			send_cmd(put_cmd(rand_text_code()));
			send_cmd(read_cmd(cursor_model - 1));
		end
		wait_idle();
	endtask

	task automatic test_scroll();
		while (cursor_model / COLUMNS < SCROLL_ROW - 1)
			send_cmd(put_cmd(CODE_NEWLINE));
		send_cmd(put_cmd(rand_text_code()));
		repeat (3)
			send_cmd(put_cmd(CODE_NEWLINE));
		send_cmd(read_cmd(cursor_model));
		send_cmd(read_cmd((SCROLL_ROW - 1) * COLUMNS - 1));
		send_cmd(read_cmd(SCROLL_ROW * COLUMNS - 1));
		send_cmd(read_cmd(SCROLL_ROW * COLUMNS));
		send_cmd(read_cmd(CELL_COUNT - 1));
		wait_idle();
	endtask

	// mostly text lines with edits and read-backs, a little raw noise
	task automatic test_random_traffic(input int unsigned n_items,
			input logic [ATTR_W-1:0] attr, input int unsigned idle_pct);
		int unsigned sent;
		int unsigned pause_at;
		int unsigned kind;
		int unsigned len;
		int          addr;
		cmd_t        c;
		write_attribute(attr);
		sender_idle_pct = idle_pct;
		sent = 0;
		pause_at = $urandom_range(n_items - 1, 1);
		while (sent < n_items) begin
			kind = $urandom_range(99);
			if (kind < 45 && kind >= 5)
				len = ($urandom_range(9) == 0) ? $urandom_range(100, 60) : $urandom_range(40, 1);
			else if (kind >= 55)
				len = $urandom_range(4, 1);
			else
				len = 1;
			for (int k = 0; k < len; k++) begin
				if (kind < 5) begin
					c = cmd_t'($urandom_range((1 << $bits(cmd_t)) - 1));
				end else if (kind < 45) begin
					c = put_cmd(rand_text_code());
				end else if (kind < 55) begin
					c = put_cmd(CODE_NEWLINE);
				end else if (kind < 70) begin
					c = put_cmd(CODE_BACKSPACE);
				end else if ($urandom_range(1) == 0) begin
					addr = int'(cursor_model) + int'($urandom_range(20))
						- int'($urandom_range(100));
					if (addr < 0)
						addr = 0;
					c = read_cmd(addr);
				end else begin
					c = read_cmd($urandom_range(ADDR_MAX));
				end
				send_cmd(c);
				sent++;
				if (sent == pause_at)
					wait_idle();
			end
		end
		wait_idle();
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && result_valid === 1'b1) begin
			if (screen_rsp_q.size() == 0) begin
				report_mismatch("result with none pending", '0, result);
			end else begin
				want = screen_rsp_q.pop_front();
				if (result.cursor_position !== want.cursor_position)
					report_mismatch("cursor_position", want.cursor_position,
						result.cursor_position);
				if (result.cell_word !== want.cell_word)
					report_mismatch("cell_word", want.cell_word, result.cell_word);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatch_count = 0;
		sender_idle_pct = 0;
		attr_model = ATTR_RESET;
		cursor_model = '0;
		foreach (screen_model[i])
			screen_model[i] = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_put_special_cases();
		test_attribute_register();
		test_scroll();
		test_random_traffic(400, 8'hFF, 0);
		test_random_traffic(400, 8'h00, 77);
		test_random_traffic(400, ATTR_W'($urandom_range(255)), 15);
		test_random_traffic(300, ATTR_W'($urandom_range(255)), 0);

		wait_idle();
		if (mismatch_count == 0 && screen_rsp_q.size() == 0)
			$display("tb_text_mode_screen_writer_unit: PASS");
		else
			$display("tb_text_mode_screen_writer_unit: FAIL");
		$finish;
	end

endmodule

FILE: text_mode_screen_writer_unit.f
+incdir+src
src/tmsw_pkg.sv
src/tmsw_ram.sv
src/tmsw_regs.sv
src/tmsw_cursor.sv
src/text_mode_screen_writer_unit.sv
src/tmsw_checker.sv
tb/tb_text_mode_screen_writer_unit.sv
